// ===== design/hftl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hftl_pkg
// Item types, register indexes, numeric constants and a 32-bit saturation function of the hair strand stepper.
// ----------------------------------------------------------------------------
package hftl_pkg;

    typedef struct packed {
        logic        cmd;
        logic [5:0]  index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic [15:0] time_step;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  out_index;
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [31:0] den;
    } div_req_t;

    localparam logic       CMD_WRITE = 1'b0;
    localparam logic [1:0] REG_COUNT = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;
    localparam logic [1:0] REG_GRAV  = 2'd2;
    localparam logic [1:0] REG_GAIN  = 2'd3;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > S32_MAX)
            return 32'sh7fffffff;
        else if (v < S32_MIN)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== design/hftl_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hftl_div
// Unsigned 64 by 32 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hftl_div
    import hftl_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire div_req_t    req,
    output logic             done,
    output logic [63:0]      quot
);
    logic [63:0] q_reg;
    logic [32:0] r_reg;
    logic [31:0] d_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [33:0] diff;

    assign trial = {r_reg[31:0], q_reg[63]};
    assign diff  = {1'b0, trial} - {2'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg <= req.num;
            r_reg <= '0;
            d_reg <= req.den;
        end
        else if (busy_reg)
        begin
            if (!diff[33])
            begin
                r_reg <= diff[32:0];
                q_reg <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

// ===== design/hair_follow_the_leader_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hair_follow_the_leader_step
// Follow-the-leader hair strand stepper, Q16.16, state in two block memories.
// ----------------------------------------------------------------------------
// A write item is taken while idle and never raises busy. A step item
// moves particles 1 .. n-1 in turn through one shared 64-bit bit-serial
// divider. A particle that stays within the segment length goes through
// read and set-up, the new position, three velocity quotients and
// write-back. When its length is limited, a square root (one result bit a
// cycle) and three length quotients come before the new position.
// After reset a pass clears every memory entry; busy is high then.
// Results appear on done for one cycle each and cannot be stalled.
module hair_follow_the_leader_step
    import hftl_pkg::*;
#(
    parameter int MAX_PARTICLES = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire in_item_t    item_in,
    output logic             done,
    output out_item_t        item_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_RD0   = 5'd2;
    localparam logic [4:0] S_RD1   = 5'd3;
    localparam logic [4:0] S_MUL   = 5'd4;
    localparam logic [4:0] S_PRED  = 5'd5;
    localparam logic [4:0] S_DIFF  = 5'd6;
    localparam logic [4:0] S_SHIFT = 5'd7;
    localparam logic [4:0] S_SQ    = 5'd8;
    localparam logic [4:0] S_SUM   = 5'd9;
    localparam logic [4:0] S_SQRT  = 5'd10;
    localparam logic [4:0] S_LMUL  = 5'd11;
    localparam logic [4:0] S_LDIV  = 5'd12;
    localparam logic [4:0] S_NEW   = 5'd13;
    localparam logic [4:0] S_NUM   = 5'd14;
    localparam logic [4:0] S_VDIV  = 5'd15;
    localparam logic [4:0] S_WB    = 5'd16;

    // registers
    logic [6:0]  seg_count_reg;
    logic [30:0] seg_len_reg;
    logic [31:0] grav_reg;
    logic [15:0] gain_reg;

    logic        cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg <= 7'd12;
            seg_len_reg   <= 31'd16384;
            grav_reg      <= '0;
            gain_reg      <= 16'd58982;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_COUNT: seg_count_reg <= pwdata[6:0];
                REG_LEN:   seg_len_reg   <= pwdata[30:0];
                REG_GRAV:  grav_reg      <= pwdata;
                REG_GAIN:  gain_reg      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COUNT: prdata = {25'd0, seg_count_reg};
            REG_LEN:   prdata = {1'b0, seg_len_reg};
            REG_GRAV:  prdata = grav_reg;
            REG_GAIN:  prdata = {16'd0, gain_reg};
            default:   prdata = '0;
        endcase
    end

    // memories
    logic [95:0] pos_mem [MAX_PARTICLES];
    logic [95:0] vel_mem [MAX_PARTICLES];
    logic        mem_we;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [95:0] pos_wdata, vel_wdata;
    logic [95:0] pos_rdata_reg, vel_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pos_mem[wr_addr] <= pos_wdata;
            vel_mem[wr_addr] <= vel_wdata;
        end
        pos_rdata_reg <= pos_mem[rd_addr];
        vel_rdata_reg <= vel_mem[rd_addr];
    end

    // control and datapath
    logic [4:0]  state_reg;
    logic [AW-1:0] idx_reg;
    logic [AW:0] n_reg;
    logic [1:0]  ax_reg;
    logic [5:0]  cnt_reg;
    logic [15:0] dt_reg;
    logic [31:0] dt2_reg;
    logic signed [31:0] f_reg   [3];
    logic signed [31:0] prev_reg[3];
    logic signed [31:0] p_reg   [3];
    logic signed [31:0] v_reg   [3];
    logic signed [63:0] a_reg   [3];
    logic signed [63:0] b_reg   [3];
    logic signed [31:0] pred_reg[3];
    logic signed [32:0] d_reg   [3];
    logic [32:0] mag_reg [3];
    logic [30:0] m_reg   [3];
    logic [61:0] sq_reg  [3];
    logic        shifted_reg;
    logic [63:0] rx_reg, rres_reg, rbit_reg;
    logic [31:0] len_reg;
    logic [61:0] lm_reg;
    logic signed [32:0] lim_reg [3];
    logic signed [31:0] np_reg  [3];
    logic signed [63:0] num_reg;
    logic        nneg_reg;
    logic signed [31:0] vnew_reg [3];
    logic [63:0] sq_sum;
    logic        clamp_now;

    div_req_t    dreq;
    logic        ddone;
    logic [63:0] dquot;

    hftl_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .done  (ddone),
        .quot  (dquot)
    );

    logic [AW:0] n_eff;
    always_comb
    begin
        if (seg_count_reg < 7'd2)
            n_eff = (AW+1)'(2);
        else if ({25'd0, seg_count_reg} > 32'(MAX_PARTICLES))
            n_eff = (AW+1)'(MAX_PARTICLES);
        else
            n_eff = seg_count_reg[AW:0];
    end

    assign sq_sum    = 64'(sq_reg[0]) + 64'(sq_reg[1]) + 64'(sq_reg[2]);
    assign clamp_now = shifted_reg || (sq_sum > 64'(seg_len_reg) * 64'(seg_len_reg));

    logic [63:0] rtest;
    assign rtest = rres_reg + rbit_reg;

    logic signed [63:0] ax_mul;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        mem_we    = 1'b0;
        wr_addr   = idx_reg;
        pos_wdata = {np_reg[2], np_reg[1], np_reg[0]};
        vel_wdata = {vnew_reg[2], vnew_reg[1], vnew_reg[0]};
        rd_addr   = idx_reg;
        dreq      = '0;
        ax_mul    = '0;
        if (state_reg == S_CLR)
        begin
            mem_we    = 1'b1;
            pos_wdata = '0;
            vel_wdata = '0;
        end
        else if (state_reg == S_IDLE && start && item_in.cmd == CMD_WRITE)
        begin
            mem_we    = ({26'd0, item_in.index} < 32'(MAX_PARTICLES));
            wr_addr   = item_in.index[AW-1:0];
            pos_wdata = {item_in.pos_z, item_in.pos_y, item_in.pos_x};
            vel_wdata = '0;
        end
        else if (state_reg == S_RD1)
            rd_addr = idx_reg - AW'(1);
        else if (state_reg == S_WB)
            mem_we = 1'b1;
        if (state_reg == S_LMUL)
            ax_mul = $signed({33'd0, m_reg[ax_reg]}) * $signed({33'd0, seg_len_reg});
        if (state_reg == S_LDIV && cnt_reg == 6'd0)
        begin
            dreq.start = 1'b1;
            dreq.num   = {2'd0, lm_reg};
            dreq.den   = len_reg;
        end
        if (state_reg == S_VDIV && cnt_reg == 6'd0)
        begin
            dreq.start = 1'b1;
            dreq.num   = num_reg[63] ? -num_reg : num_reg;
            dreq.den   = {16'd0, dt_reg};
        end
    end

    logic [AW:0] idx_ext;
    assign idx_ext = {1'b0, idx_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            idx_reg   <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            unique case (state_reg)
                S_CLR:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_ext == (AW+1)'(MAX_PARTICLES - 1))
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                    if (start && item_in.cmd != CMD_WRITE)
                    begin
                        idx_reg   <= AW'(1);
                        state_reg <= S_RD0;
                    end
                S_RD0:   state_reg <= S_RD1;
                S_RD1:   state_reg <= S_MUL;
                S_MUL:   state_reg <= S_PRED;
                S_PRED:  state_reg <= S_DIFF;
                S_DIFF:  state_reg <= S_SHIFT;
                S_SHIFT: state_reg <= S_SQ;
                S_SQ:    state_reg <= S_SUM;
                S_SUM:   state_reg <= clamp_now ? S_SQRT : S_NEW;
                S_SQRT:  if (rbit_reg == 64'd0) state_reg <= S_LMUL;
                S_LMUL:  state_reg <= S_LDIV;
                S_LDIV:
                    if (ddone)
                        state_reg <= (ax_reg == 2'd2) ? S_NEW : S_LMUL;
                S_NEW:   state_reg <= S_NUM;
                S_NUM:   state_reg <= S_VDIV;
                S_VDIV:
                    if (ddone)
                        state_reg <= (ax_reg == 2'd2) ? S_WB : S_NUM;
                S_WB:
                begin
                    done <= 1'b1;
                    if (idx_ext + (AW+1)'(1) == n_reg)
                        state_reg <= S_IDLE;
                    else
                    begin
                        idx_reg   <= idx_reg + AW'(1);
                        state_reg <= S_RD0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                dt_reg   <= (item_in.time_step == 16'd0) ? 16'd1 : item_in.time_step;
                f_reg[0] <= item_in.force_x;
                f_reg[1] <= item_in.force_y;
                f_reg[2] <= sat32(64'(item_in.force_z) + 64'($signed(grav_reg)));
                n_reg    <= n_eff;
            end
            S_RD0:
                dt2_reg <= dt_reg * dt_reg;
            S_RD1:
                for (int c = 0; c < 3; c++)
                begin
                    p_reg[c] <= pos_rdata_reg[32*c +: 32];
                    v_reg[c] <= vel_rdata_reg[32*c +: 32];
                end
            S_MUL:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prev_reg[c] <= pos_rdata_reg[32*c +: 32];
                    a_reg[c] <= $signed({48'd0, dt_reg}) * 64'(v_reg[c]);
                    b_reg[c] <= $signed({32'd0, dt2_reg}) * 64'(f_reg[c]);
                end
            end
            S_PRED:
                for (int c = 0; c < 3; c++)
                    pred_reg[c] <= sat32(64'(p_reg[c]) + (a_reg[c] >>> 16)
                                         + (b_reg[c] >>> 32));
            S_DIFF:
                for (int c = 0; c < 3; c++)
                begin
                    d_reg[c]   <= 33'(pred_reg[c]) - 33'(prev_reg[c]);
                    mag_reg[c] <= (33'(pred_reg[c]) < 33'(prev_reg[c]))
                                  ? 33'(prev_reg[c]) - 33'(pred_reg[c])
                                  : 33'(pred_reg[c]) - 33'(prev_reg[c]);
                end
            S_SHIFT:
            begin
                if (mag_reg[0][32] || mag_reg[1][32] || mag_reg[2][32])
                begin
                    shifted_reg <= 1'b1;
                    for (int c = 0; c < 3; c++) m_reg[c] <= mag_reg[c][32:2];
                end
                else if (mag_reg[0][31] || mag_reg[1][31] || mag_reg[2][31])
                begin
                    shifted_reg <= 1'b1;
                    for (int c = 0; c < 3; c++) m_reg[c] <= mag_reg[c][31:1];
                end
                else
                begin
                    shifted_reg <= 1'b0;
                    for (int c = 0; c < 3; c++) m_reg[c] <= mag_reg[c][30:0];
                end
            end
            S_SQ:
                for (int c = 0; c < 3; c++)
                    sq_reg[c] <= m_reg[c] * m_reg[c];
            S_SUM:
            begin
                rx_reg    <= sq_sum;
                rres_reg  <= '0;
                rbit_reg  <= 64'h4000_0000_0000_0000;
                ax_reg    <= 2'd0;
                for (int c = 0; c < 3; c++) lim_reg[c] <= d_reg[c];
            end
            S_SQRT:
            begin
                if (rbit_reg != 64'd0)
                begin
                    if (rx_reg >= rtest)
                    begin
                        rx_reg   <= rx_reg - rtest;
                        rres_reg <= (rres_reg >> 1) + rbit_reg;
                    end
                    else
                        rres_reg <= rres_reg >> 1;
                    rbit_reg <= rbit_reg >> 2;
                end
                else
                    len_reg <= rres_reg[31:0];
                cnt_reg <= '0;
            end
            S_LMUL:
            begin
                lm_reg  <= ax_mul[61:0];
                cnt_reg <= '0;
            end
            S_LDIV:
            begin
                cnt_reg <= 6'd1;
                if (ddone)
                begin
                    lim_reg[ax_reg] <= (len_reg == 32'd0) ? 33'sd0
                        : (d_reg[ax_reg] < 0) ? -$signed(dquot[32:0])
                                              : $signed(dquot[32:0]);
                    ax_reg  <= ax_reg + 2'd1;
                end
            end
            S_NEW:
            begin
                for (int c = 0; c < 3; c++)
                    np_reg[c] <= sat32(64'(prev_reg[c]) + 64'(lim_reg[c]));
                ax_reg <= 2'd0;
            end
            S_NUM:
            begin
                num_reg <= ((64'(np_reg[ax_reg]) - 64'(p_reg[ax_reg])) <<< 16)
                         - $signed({48'd0, gain_reg})
                           * (64'(np_reg[ax_reg]) - 64'(pred_reg[ax_reg]));
                cnt_reg <= '0;
            end
            S_VDIV:
            begin
                cnt_reg <= 6'd1;
                if (cnt_reg == 6'd0)
                    nneg_reg <= num_reg[63];
                if (ddone)
                begin
                    vnew_reg[ax_reg] <= sat32(nneg_reg ? -$signed(dquot) : $signed(dquot));
                    ax_reg <= ax_reg + 2'd1;
                end
            end
            S_WB:
            begin
                item_out.out_index <= 6'(idx_reg);
                item_out.new_x     <= np_reg[0];
                item_out.new_y     <= np_reg[1];
                item_out.new_z     <= np_reg[2];
                item_out.last      <= (idx_ext + (AW+1)'(1) == n_reg);
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire
